>>> hw/rtl/mqtt_server_packet_parser_unit_macros.svh
// assertion macros shared by the checker of the packet parser
// needs clk and rst_n in the scope where a macro is used
`ifndef MQTT_SERVER_PACKET_PARSER_UNIT_MACROS_SVH
`define MQTT_SERVER_PACKET_PARSER_UNIT_MACROS_SVH

// same-cycle implication, masked during reset
`define MQTT_PP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, masked during reset
`define MQTT_PP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// next-cycle implication that also holds across reset
`define MQTT_PP_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/mqtt_pp_pkg.sv
// shared types and constants of the packet parser
// no dependencies
package mqtt_pp_pkg;

  localparam int MAX_FILTERS_DEF = 16;
  localparam int FCNT_W          = 6;   // holds up to 63 filters
  localparam int IDX_W           = 7;   // up to 1 + 4 + 63 results per byte
  localparam int QUEUE_DEPTH     = 4;
  localparam int PADDR_W         = 3;

  localparam logic [2:0] KIND_REPLY   = 3'd0;
  localparam logic [2:0] KIND_TOPIC   = 3'd1;
  localparam logic [2:0] KIND_PAYLOAD = 3'd2;
  localparam logic [2:0] KIND_FILTER  = 3'd3;
  localparam logic [2:0] KIND_UNKNOWN = 3'd4;

  localparam logic [3:0] TYPE_CONNECT   = 4'd1;
  localparam logic [3:0] TYPE_PUBLISH   = 4'd3;
  localparam logic [3:0] TYPE_SUBSCRIBE = 4'd8;
  localparam logic [3:0] TYPE_PINGREQ   = 4'd12;

  localparam logic [7:0] BYTE_CONNACK  = 8'h20;
  localparam logic [7:0] BYTE_PUBACK   = 8'h40;
  localparam logic [7:0] BYTE_SUBACK   = 8'h90;
  localparam logic [7:0] BYTE_PINGRESP = 8'hD0;

  localparam logic [PADDR_W-1:0] ADDR_GRANTED_QOS = 3'd0;

  // work handed from the parser to the reply sequencer
  typedef struct packed {
    logic              data_vld;
    logic [7:0]        data_byte;
    logic [2:0]        data_kind;
    logic [3:0]        fnum;
    logic              rep_vld;
    logic [7:0]        ctrl;
    logic [15:0]       pid;
    logic [FCNT_W-1:0] fcnt;
  } job_t;

endpackage

>>> hw/rtl/mqtt_pp_if.sv
// byte stream channels of the packet parser
// depends on nothing
interface mqtt_pp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       session_start;
  modport source (output valid, in_byte, session_start, input ready);
  modport sink (input valid, in_byte, session_start, output ready);
endinterface

interface mqtt_pp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [2:0] out_kind;
  logic [3:0] filter_number;
  logic [3:0] packet_kind;
  logic       last;
  modport source (output valid, out_byte, out_kind, filter_number, packet_kind, last,
                  input ready);
  modport sink (input valid, out_byte, out_kind, filter_number, packet_kind, last,
                output ready);
endinterface

>>> hw/rtl/mqtt_server_packet_parser_unit.sv
// Broker-side control packet parser, one client byte per transfer.
// in_ch carries in_byte and session_start; session_start set drops any partial
// packet so that this byte is read as a control byte. out_ch carries result
// items: topic, payload and filter bytes, reply bytes at packet end, or one
// unknown-type marker; last flags the final result caused by one input byte.
// Throughput: one input byte per cycle while the job queue has room. The result
// side emits one result per cycle while out_ch.ready is high; a byte causing n
// results holds the back end until all n are sent (at most 1 + 4 + MAX_FILTERS
// for a SUBACK), and the QUEUE_DEPTH-entry job queue lets the front keep taking
// bytes meanwhile. A byte's job is registered in the queue and its first result
// then in the output register. Bytes that cause no result (header, length, ids)
// never enter the queue. When out_ch.ready is low the output register holds, the
// queue fills and in_ch.ready then falls. Reset (rst_n low, synchronous) empties
// the queue, drops the output and returns the parser to await a control byte, with
// granted_qos set to 2. granted_qos is written over APB at address 0.
module mqtt_server_packet_parser_unit #(
  parameter int MAX_FILTERS = mqtt_pp_pkg::MAX_FILTERS_DEF,
  parameter int QUEUE_DEPTH = mqtt_pp_pkg::QUEUE_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst_n,
  mqtt_pp_in_if.sink                        in_ch,
  mqtt_pp_out_if.source                     out_ch,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [mqtt_pp_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  mqtt_pp_pkg::job_t wr_job, rd_job;
  logic push, pop, full, empty, take;
  logic [1:0] qos_r;

  assign in_ch.ready = !full;
  assign take        = in_ch.valid && !full;
  assign pready      = 1'b1;
  assign prdata      = (paddr[mqtt_pp_pkg::PADDR_W-1:2] == mqtt_pp_pkg::ADDR_GRANTED_QOS[
                        mqtt_pp_pkg::PADDR_W-1:2]) ? {30'd0, qos_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qos_r <= 2'd2;
    end else if (psel && penable && pwrite &&
                 paddr[mqtt_pp_pkg::PADDR_W-1:2] ==
                 mqtt_pp_pkg::ADDR_GRANTED_QOS[mqtt_pp_pkg::PADDR_W-1:2]) begin
      qos_r <= pwdata[1:0];
    end
  end

  mqtt_pp_front #(.MAX_FILTERS(MAX_FILTERS)) u_front (
    .clk(clk), .rst_n(rst_n), .take(take), .b(in_ch.in_byte),
    .ss(in_ch.session_start), .push(push), .job(wr_job)
  );

  mqtt_pp_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk(clk), .rst_n(rst_n), .push(push), .wr_job(wr_job), .full(full),
    .pop(pop), .empty(empty), .rd_job(rd_job)
  );

  mqtt_pp_back u_back (
    .clk(clk), .rst_n(rst_n), .empty(empty), .job(rd_job), .qos(qos_r),
    .pop(pop), .out_ch(out_ch)
  );

endmodule

>>> hw/rtl/mqtt_pp_front.sv
// byte parser: fixed header, remaining length and body fields
// depends on mqtt_pp_pkg
module mqtt_pp_front #(
  parameter int MAX_FILTERS = mqtt_pp_pkg::MAX_FILTERS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              take,
  input  logic [7:0]        b,
  input  logic              ss,
  output logic              push,
  output mqtt_pp_pkg::job_t job
);

  localparam logic [3:0] PH_AWAIT   = 4'd0;
  localparam logic [3:0] PH_LEN     = 4'd1;
  localparam logic [3:0] PH_SKIP    = 4'd2;
  localparam logic [3:0] PH_PTL_HI  = 4'd3;
  localparam logic [3:0] PH_PTL_LO  = 4'd4;
  localparam logic [3:0] PH_PTOPIC  = 4'd5;
  localparam logic [3:0] PH_PID_HI  = 4'd6;
  localparam logic [3:0] PH_PID_LO  = 4'd7;
  localparam logic [3:0] PH_PAYLOAD = 4'd8;
  localparam logic [3:0] PH_SID_HI  = 4'd9;
  localparam logic [3:0] PH_SID_LO  = 4'd10;
  localparam logic [3:0] PH_FL_HI   = 4'd11;
  localparam logic [3:0] PH_FL_LO   = 4'd12;
  localparam logic [3:0] PH_FILTER  = 4'd13;
  localparam logic [3:0] PH_QOS     = 4'd14;
  localparam int FW = mqtt_pp_pkg::FCNT_W;

  logic [3:0]  phase_r, phase_nxt, ph;
  logic [7:0]  ctrl_r, ctrl_nxt, ctrl;
  logic [27:0] rem_r, rem_nxt, rem;
  logic [1:0]  lg_r, lg_nxt, lg;
  logic [15:0] fc_r, fc_nxt, fc;
  logic [15:0] pid_r, pid_nxt, pid;
  logic [FW-1:0] fcnt_r, fcnt_nxt, fcnt;
  logic [27:0] grp;
  logic [3:0]  after_topic;

  always_comb begin
    ph   = ss ? PH_AWAIT : phase_r;
    ctrl = ss ? 8'd0 : ctrl_r;
    rem  = ss ? 28'd0 : rem_r;
    lg   = ss ? 2'd0 : lg_r;
    fc   = ss ? 16'd0 : fc_r;
    pid  = ss ? 16'd0 : pid_r;
    fcnt = ss ? '0 : fcnt_r;
    phase_nxt = ph;
    ctrl_nxt  = ctrl;
    rem_nxt   = rem;
    lg_nxt    = lg;
    fc_nxt    = fc;
    pid_nxt   = pid;
    fcnt_nxt  = fcnt;
    job       = '0;
    after_topic = (ctrl[2:1] != 2'd0) ? PH_PID_HI : PH_PAYLOAD;
    case (lg)
      2'd0:    grp = {21'd0, b[6:0]};
      2'd1:    grp = {14'd0, b[6:0], 7'd0};
      2'd2:    grp = {7'd0, b[6:0], 14'd0};
      default: grp = {b[6:0], 21'd0};
    endcase
    if (ph == PH_AWAIT) begin
      ctrl_nxt  = b;
      rem_nxt   = '0;
      lg_nxt    = '0;
      phase_nxt = PH_LEN;
    end else if (ph == PH_LEN) begin
      rem_nxt = rem | grp;
      if (b[7] && lg != 2'd3) begin
        lg_nxt = lg + 2'd1;
      end else begin
        fc_nxt   = '0;
        pid_nxt  = '0;
        fcnt_nxt = '0;
        if (ctrl[7:4] == mqtt_pp_pkg::TYPE_PUBLISH) phase_nxt = PH_PTL_HI;
        else if (ctrl[7:4] == mqtt_pp_pkg::TYPE_SUBSCRIBE) phase_nxt = PH_SID_HI;
        else phase_nxt = PH_SKIP;
        if (rem_nxt == 28'd0) begin
          job.rep_vld = 1'b1;
          phase_nxt   = PH_AWAIT;
        end
      end
    end else begin
      job.fnum = (fcnt != '0) ? 4'(fcnt - FW'(1)) : 4'd0;
      job.data_byte = b;
      case (ph)
        PH_PTL_HI: begin
          fc_nxt = {b, 8'd0};
          phase_nxt = PH_PTL_LO;
        end
        PH_PTL_LO: begin
          fc_nxt = fc | {8'd0, b};
          phase_nxt = (fc_nxt != 16'd0) ? PH_PTOPIC : after_topic;
        end
        PH_PTOPIC: begin
          job.data_vld  = 1'b1;
          job.data_kind = mqtt_pp_pkg::KIND_TOPIC;
          job.fnum      = 4'd0;
          fc_nxt = fc - 16'd1;
          if (fc_nxt == 16'd0) phase_nxt = after_topic;
        end
        PH_PID_HI: begin
          pid_nxt = {b, 8'd0};
          phase_nxt = PH_PID_LO;
        end
        PH_PID_LO: begin
          pid_nxt = pid | {8'd0, b};
          phase_nxt = PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          job.data_vld  = 1'b1;
          job.data_kind = mqtt_pp_pkg::KIND_PAYLOAD;
          job.fnum      = 4'd0;
        end
        PH_SID_HI: begin
          pid_nxt = {b, 8'd0};
          phase_nxt = PH_SID_LO;
        end
        PH_SID_LO: begin
          pid_nxt = pid | {8'd0, b};
          phase_nxt = PH_FL_HI;
        end
        PH_FL_HI: begin
          if (fcnt < FW'(MAX_FILTERS)) fcnt_nxt = fcnt + FW'(1);
          fc_nxt = {b, 8'd0};
          phase_nxt = PH_FL_LO;
        end
        PH_FL_LO: begin
          fc_nxt = fc | {8'd0, b};
          phase_nxt = (fc_nxt != 16'd0) ? PH_FILTER : PH_QOS;
        end
        PH_FILTER: begin
          job.data_vld  = 1'b1;
          job.data_kind = mqtt_pp_pkg::KIND_FILTER;
          fc_nxt = fc - 16'd1;
          if (fc_nxt == 16'd0) phase_nxt = PH_QOS;
        end
        PH_QOS: phase_nxt = PH_FL_HI;
        default: ;
      endcase
      if (rem != 28'd0) rem_nxt = rem - 28'd1;
      if (rem_nxt == 28'd0) begin
        job.rep_vld = 1'b1;
        phase_nxt   = PH_AWAIT;
      end
    end
    job.ctrl = ctrl_nxt;
    job.pid  = pid_nxt;
    job.fcnt = fcnt_nxt;
    push = take && (job.data_vld || job.rep_vld);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_AWAIT;
      ctrl_r  <= '0;
      rem_r   <= '0;
      lg_r    <= '0;
      fc_r    <= '0;
      pid_r   <= '0;
      fcnt_r  <= '0;
    end else if (take) begin
      phase_r <= phase_nxt;
      ctrl_r  <= ctrl_nxt;
      rem_r   <= rem_nxt;
      lg_r    <= lg_nxt;
      fc_r    <= fc_nxt;
      pid_r   <= pid_nxt;
      fcnt_r  <= fcnt_nxt;
    end
  end

endmodule

>>> hw/rtl/mqtt_pp_fifo.sv
// short register queue of parser jobs between front and back
// depends on mqtt_pp_pkg
module mqtt_pp_fifo #(
  parameter int DEPTH = mqtt_pp_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  mqtt_pp_pkg::job_t wr_job,
  output logic              full,
  input  logic              pop,
  output logic              empty,
  output mqtt_pp_pkg::job_t rd_job
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  mqtt_pp_pkg::job_t mem_r [DEPTH];
  logic [PW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign full   = (cnt_r == CW'(DEPTH));
  assign empty  = (cnt_r == '0);
  assign rd_job = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) wp_nxt = (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + PW'(1);
    if (pop) rp_nxt = (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + PW'(1);
    if (push && !pop) cnt_nxt = cnt_r + CW'(1);
    else if (pop && !push) cnt_nxt = cnt_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wr_job;
  end

endmodule

>>> hw/rtl/mqtt_pp_back.sv
// result sequencer: expands a job into data and reply bytes
// depends on mqtt_pp_pkg and mqtt_pp_if
module mqtt_pp_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                empty,
  input  mqtt_pp_pkg::job_t   job,
  input  logic [1:0]          qos,
  output logic                pop,
  mqtt_pp_out_if.source       out_ch
);

  localparam int IW = mqtt_pp_pkg::IDX_W;

  logic [IW-1:0] idx_r, idx_nxt, total, r;
  logic          vld_r, load, is_last;
  logic [7:0]    byte_r, byte_nxt;
  logic [2:0]    kind_r, kind_nxt;
  logic [3:0]    fnum_r, fnum_nxt, pk_r;
  logic          last_r;
  logic [3:0]    ty;

  assign ty   = job.ctrl[7:4];
  assign load = !empty && (!vld_r || out_ch.ready);

  always_comb begin
    total = IW'(job.data_vld);
    if (job.rep_vld) begin
      case (ty)
        mqtt_pp_pkg::TYPE_CONNECT:   total = total + IW'(4);
        mqtt_pp_pkg::TYPE_PUBLISH:   total = total + IW'(4);
        mqtt_pp_pkg::TYPE_SUBSCRIBE: total = total + IW'(4) + IW'(job.fcnt);
        mqtt_pp_pkg::TYPE_PINGREQ:   total = total + IW'(2);
        default:                     total = total + IW'(1);
      endcase
    end
    is_last  = (idx_r == total - IW'(1));
    r        = idx_r - IW'(job.data_vld);
    kind_nxt = mqtt_pp_pkg::KIND_REPLY;
    fnum_nxt = 4'd0;
    byte_nxt = 8'd0;
    if (job.data_vld && idx_r == '0) begin
      byte_nxt = job.data_byte;
      kind_nxt = job.data_kind;
      fnum_nxt = job.fnum;
    end else begin
      case (ty)
        mqtt_pp_pkg::TYPE_CONNECT: begin
          if (r == IW'(0)) byte_nxt = mqtt_pp_pkg::BYTE_CONNACK;
          else if (r == IW'(1)) byte_nxt = 8'd2;
        end
        mqtt_pp_pkg::TYPE_PUBLISH: begin
          if (r == IW'(0)) byte_nxt = mqtt_pp_pkg::BYTE_PUBACK;
          else if (r == IW'(1)) byte_nxt = 8'd2;
          else if (r == IW'(2)) byte_nxt = job.pid[15:8];
          else byte_nxt = job.pid[7:0];
        end
        mqtt_pp_pkg::TYPE_SUBSCRIBE: begin
          if (r == IW'(0)) byte_nxt = mqtt_pp_pkg::BYTE_SUBACK;
          else if (r == IW'(1)) byte_nxt = 8'(job.fcnt) + 8'd2;
          else if (r == IW'(2)) byte_nxt = job.pid[15:8];
          else if (r == IW'(3)) byte_nxt = job.pid[7:0];
          else byte_nxt = {6'd0, qos};
        end
        mqtt_pp_pkg::TYPE_PINGREQ: begin
          if (r == IW'(0)) byte_nxt = mqtt_pp_pkg::BYTE_PINGRESP;
        end
        default: begin
          byte_nxt = job.ctrl;
          kind_nxt = mqtt_pp_pkg::KIND_UNKNOWN;
        end
      endcase
    end
    idx_nxt = idx_r;
    if (load) idx_nxt = is_last ? '0 : idx_r + IW'(1);
  end

  assign pop = load && is_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      idx_r <= '0;
    end else begin
      idx_r <= idx_nxt;
      if (load) vld_r <= 1'b1;
      else if (out_ch.ready) vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= byte_nxt;
      kind_r <= kind_nxt;
      fnum_r <= fnum_nxt;
      pk_r   <= ty;
      last_r <= is_last;
    end
  end

  assign out_ch.valid         = vld_r;
  assign out_ch.out_byte      = byte_r;
  assign out_ch.out_kind      = kind_r;
  assign out_ch.filter_number = fnum_r;
  assign out_ch.packet_kind   = pk_r;
  assign out_ch.last          = last_r;

endmodule

>>> hw/rtl/mqtt_pp_checker.sv
// port-level checks of the packet parser, bound to the top level
// depends on mqtt_server_packet_parser_unit_macros.svh
`include "mqtt_server_packet_parser_unit_macros.svh"

module mqtt_pp_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] out_kind,
  input logic [3:0] filter_number
);

  `MQTT_PP_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
  `MQTT_PP_ASSERT_NOW(a_kind, out_valid, out_kind <= 3'd4, "result kind out of range")
  `MQTT_PP_ASSERT_NOW(a_fnum, out_valid && out_kind != 3'd3, filter_number == 4'd0, "filter index on non-filter result")
  `MQTT_PP_ASSERT_RST(a_rst, !rst_n, !out_valid, "result valid after reset")

endmodule

bind mqtt_server_packet_parser_unit mqtt_pp_checker u_checker (
  .clk(clk), .rst_n(rst_n), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_kind(out_ch.out_kind), .filter_number(out_ch.filter_number)
);
